### rtl/aprt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aprt_pkg
// Shared types and codes of the aging pair report table.
// ----------------------------------------------------------------------------
package aprt_pkg;

  localparam int KEY_W        = 48;
  localparam int REP_W        = 24;
  localparam int EXP_W        = 16;
  localparam int RESULT_LIMIT = 64;
  localparam int CNT_W        = 7;

  typedef enum logic [2:0] {
    OP_UPSERT = 3'd0,
    OP_LOOKUP = 3'd1,
    OP_DUMP   = 3'd2,
    OP_TICK   = 3'd3,
    OP_SWEEP  = 3'd4
  } op_e_t;

  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_UPDATE = 2'd1;
  localparam logic [1:0] KIND_DUMP   = 2'd2;
  localparam logic [1:0] KIND_ACK    = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PLACE,
    S_FLUSH
  } state_t;

  // entry without its time stamp (stamp width is a top-level parameter)
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] sta;
    logic [KEY_W-1:0] bss;
    logic [REP_W-1:0] rep;
  } ent_t;

  typedef struct packed {
    logic [2:0]       op;
    logic [KEY_W-1:0] sta;
    logic [KEY_W-1:0] bss;
    logic [REP_W-1:0] rep;
  } qry_t;

  typedef struct packed {
    logic match;
    logic fresh;
  } hd_flags_t;

endpackage

### rtl/aging_pair_report_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_pair_report_table_core
// Beacon report table keyed by (station, BSSID) with tick-based aging.
// ----------------------------------------------------------------------------
// Input items arrive on in_* (opcode in in_tuser, key and report in
// in_tdata); results leave on out_* (kind and status in out_tuser, tlast on
// the final result of an item). cfg_* writes the expiry in ticks.
// The slots sit in a ring of cells that rotates one slot per cycle past a
// single head cell, which compares the key and ages the entry. One item is
// handled at a time. A tick goes straight to its result; lookup, dump,
// sweep and an upsert of a known pair take one rotation of the ring; an
// upsert of a new pair takes a second rotation that places it in the first
// stale or empty slot, or reports full if there is none.
// The ring advances only while the output register is free, so a stalled
// receiver freezes the rotation and no result is lost; dump results stream
// out during the rotation. Reset clears all valid bits, the time counter and
// sets the expiry to 10 ticks; the block is ready in the cycle after reset.
// Opcodes above sweep are taken and dropped without a result.
// ----------------------------------------------------------------------------
module aging_pair_report_table_core import aprt_pkg::*; #(
  parameter int ENTRIES   = 64,
  parameter int TIME_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // station_address, neighbour_bssid, in_op_class, in_channel, in_rcpi
  input  logic [119:0]     in_tdata,
  // opcode
  input  logic [2:0]       in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // out_station, out_bssid, out_op_class, out_channel, out_rcpi
  output logic [119:0]     out_tdata,
  // kind, status
  output logic [3:0]       out_tuser,
  output logic             out_tlast,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [EXP_W-1:0] cfg_data
);

  localparam int IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  state_t               state_r, state_nxt;
  qry_t                 qry_r;
  logic [TIME_BITS-1:0] now_r;
  logic [EXP_W-1:0]     expire_r;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic                 found_r, found_nxt;
  logic                 free_ok_r, free_ok_nxt;
  logic [IW-1:0]        free_idx_r, free_idx_nxt;
  logic                 hit_r, hit_nxt;
  logic [REP_W-1:0]     rep_hit_r, rep_hit_nxt;
  logic                 pend_v_r, pend_v_nxt;
  ent_t                 pend_r, pend_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_kind_r, out_kind_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic [KEY_W-1:0]     out_sta_r, out_sta_nxt;
  logic [KEY_W-1:0]     out_bss_r, out_bss_nxt;
  logic [REP_W-1:0]     out_rep_r, out_rep_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_load;

  ent_t                 cell_q [ENTRIES];
  logic [TIME_BITS-1:0] cell_s [ENTRIES];
  ent_t                 head_ent;
  logic [TIME_BITS-1:0] head_stamp;
  hd_flags_t            flags;
  logic                 shift;
  logic                 out_free;
  logic                 in_acc;
  logic                 write_here;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign shift     = ((state_r == S_SCAN) || (state_r == S_PLACE)) && out_free;
  assign write_here = (state_r == S_PLACE) && (idx_r == free_idx_r);

  // ring of slots
  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    if (k == ENTRIES - 1) begin : g_tail
      aprt_cell #(.TIME_BITS(TIME_BITS)) u_cell (
        .clk(clk), .rst_n(rst_n), .shift(shift),
        .d_ent(head_ent), .d_stamp(head_stamp),
        .q_ent(cell_q[k]), .q_stamp(cell_s[k])
      );
    end else begin : g_mid
      aprt_cell #(.TIME_BITS(TIME_BITS)) u_cell (
        .clk(clk), .rst_n(rst_n), .shift(shift),
        .d_ent(cell_q[k+1]), .d_stamp(cell_s[k+1]),
        .q_ent(cell_q[k]), .q_stamp(cell_s[k])
      );
    end
  end

  aprt_head #(.TIME_BITS(TIME_BITS)) u_head (
    .ent(cell_q[0]), .stamp(cell_s[0]), .now(now_r), .expire(expire_r),
    .qry(qry_r), .write_here(write_here),
    .ent_new(head_ent), .stamp_new(head_stamp), .flags(flags)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      now_r       <= '0;
      expire_r    <= EXP_W'(10);
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      found_r     <= 1'b0;
      free_ok_r   <= 1'b0;
      hit_r       <= 1'b0;
      pend_v_r    <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      free_ok_r   <= free_ok_nxt;
      hit_r       <= hit_nxt;
      pend_v_r    <= pend_v_nxt;
      cnt_r       <= cnt_nxt;
      if (in_acc && (in_tuser == OP_TICK)) begin
        now_r <= now_r + 1'b1;
      end
      if (cfg_valid) begin
        expire_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      qry_r.op  <= in_tuser;
      qry_r.sta <= in_tdata[47:0];
      qry_r.bss <= in_tdata[95:48];
      qry_r.rep <= in_tdata[119:96];
    end
    free_idx_r <= free_idx_nxt;
    rep_hit_r  <= rep_hit_nxt;
    pend_r     <= pend_nxt;
    if (out_load) begin
      out_kind_r   <= out_kind_nxt;
      out_status_r <= out_status_nxt;
      out_sta_r    <= out_sta_nxt;
      out_bss_r    <= out_bss_nxt;
      out_rep_r    <= out_rep_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    found_nxt      = found_r;
    free_ok_nxt    = free_ok_r;
    free_idx_nxt   = free_idx_r;
    hit_nxt        = hit_r;
    rep_hit_nxt    = rep_hit_r;
    pend_v_nxt     = pend_v_r;
    pend_nxt       = pend_r;
    cnt_nxt        = cnt_r;
    out_load       = 1'b0;
    out_kind_nxt   = KIND_ACK;
    out_status_nxt = ST_OK;
    out_sta_nxt    = '0;
    out_bss_nxt    = '0;
    out_rep_nxt    = '0;
    out_last_nxt   = 1'b1;
    out_valid_nxt  = out_valid_r && !out_tready;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          idx_nxt     = '0;
          found_nxt   = 1'b0;
          free_ok_nxt = 1'b0;
          hit_nxt     = 1'b0;
          pend_v_nxt  = 1'b0;
          cnt_nxt     = '0;
          case (in_tuser)
            OP_UPSERT, OP_LOOKUP, OP_DUMP, OP_SWEEP: state_nxt = S_SCAN;
            OP_TICK:                                 state_nxt = S_FLUSH;
            default:                                 state_nxt = S_IDLE;
          endcase
        end
      end

      S_SCAN: begin
        if (shift) begin
          case (qry_r.op)
            OP_UPSERT: begin
              if (flags.match) begin
                found_nxt = 1'b1;
              end
              if (!flags.fresh && !free_ok_r) begin
                free_ok_nxt  = 1'b1;
                free_idx_nxt = idx_r;
              end
            end
            OP_LOOKUP: begin
              if (flags.fresh && flags.match && !hit_r) begin
                hit_nxt     = 1'b1;
                rep_hit_nxt = cell_q[0].rep;
              end
            end
            OP_DUMP: begin
              if (flags.fresh && (cnt_r < CNT_W'(RESULT_LIMIT))) begin
                if (pend_v_r) begin
                  out_load       = 1'b1;
                  out_valid_nxt  = 1'b1;
                  out_kind_nxt   = KIND_DUMP;
                  out_status_nxt = ST_OK;
                  out_sta_nxt    = pend_r.sta;
                  out_bss_nxt    = pend_r.bss;
                  out_rep_nxt    = pend_r.rep;
                  out_last_nxt   = 1'b0;
                end
                pend_v_nxt = 1'b1;
                pend_nxt   = cell_q[0];
                cnt_nxt    = cnt_r + 1'b1;
              end
            end
            default: begin
            end
          endcase
          if (idx_r == LAST_IDX) begin
            idx_nxt = '0;
            if ((qry_r.op == OP_UPSERT) && !found_nxt && free_ok_nxt) begin
              state_nxt = S_PLACE;
            end else begin
              state_nxt = S_FLUSH;
            end
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      S_PLACE: begin
        if (shift) begin
          if (idx_r == LAST_IDX) begin
            idx_nxt   = '0;
            found_nxt = 1'b1;
            state_nxt = S_FLUSH;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          case (qry_r.op)
            OP_UPSERT: begin
              out_kind_nxt   = KIND_UPDATE;
              out_status_nxt = found_r ? ST_OK : ST_FULL;
              out_sta_nxt    = qry_r.sta;
              out_bss_nxt    = qry_r.bss;
              out_rep_nxt    = found_r ? qry_r.rep : '0;
            end
            OP_LOOKUP: begin
              out_kind_nxt   = KIND_LOOKUP;
              out_status_nxt = hit_r ? ST_OK : ST_MISS;
              out_sta_nxt    = qry_r.sta;
              out_bss_nxt    = qry_r.bss;
              out_rep_nxt    = hit_r ? rep_hit_r : '0;
            end
            OP_DUMP: begin
              out_kind_nxt   = KIND_DUMP;
              out_status_nxt = pend_v_r ? ST_OK : ST_EMPTY;
              out_sta_nxt    = pend_v_r ? pend_r.sta : '0;
              out_bss_nxt    = pend_v_r ? pend_r.bss : '0;
              out_rep_nxt    = pend_v_r ? pend_r.rep : '0;
            end
            default: begin
            end
          endcase
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_rep_r, out_bss_r, out_sta_r};
  assign out_tuser  = {out_status_r, out_kind_r};
  assign out_tlast  = out_last_r;

endmodule

### rtl/aprt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aprt_cell
// One table slot in the ring; takes its neighbor's entry on each shift.
// ----------------------------------------------------------------------------
module aprt_cell import aprt_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 shift,
  input  ent_t                 d_ent,
  input  logic [TIME_BITS-1:0] d_stamp,
  output ent_t                 q_ent,
  output logic [TIME_BITS-1:0] q_stamp
);

  logic                 valid_r;
  ent_t                 ent_r;
  logic [TIME_BITS-1:0] stamp_r;

  // valid bit is control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift) begin
      valid_r <= d_ent.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (shift) begin
      ent_r   <= d_ent;
      stamp_r <= d_stamp;
    end
  end

  always_comb begin
    q_ent       = ent_r;
    q_ent.valid = valid_r;
  end
  assign q_stamp = stamp_r;

endmodule

### rtl/aprt_head.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aprt_head
// Examines the slot at the ring head and forms its updated value.
// ----------------------------------------------------------------------------
module aprt_head import aprt_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  ent_t                 ent,
  input  logic [TIME_BITS-1:0] stamp,
  input  logic [TIME_BITS-1:0] now,
  input  logic [EXP_W-1:0]     expire,
  input  qry_t                 qry,
  input  logic                 write_here,
  output ent_t                 ent_new,
  output logic [TIME_BITS-1:0] stamp_new,
  output hd_flags_t            flags
);

  localparam int CW = (TIME_BITS > EXP_W) ? TIME_BITS : EXP_W;

  logic [TIME_BITS-1:0] age;
  logic [CW-1:0]        age_x;
  logic [CW-1:0]        exp_x;

  // age modulo time width against expiry
  assign age   = now - stamp;
  assign age_x = CW'(age);
  assign exp_x = CW'(expire);

  assign flags.match = ent.valid && (ent.sta == qry.sta) && (ent.bss == qry.bss);
  assign flags.fresh = ent.valid && (age_x < exp_x);

  // write, refresh or invalidate
  always_comb begin
    ent_new   = ent;
    stamp_new = stamp;
    if (write_here || ((qry.op == OP_UPSERT) && flags.match)) begin
      ent_new.valid = 1'b1;
      ent_new.sta   = qry.sta;
      ent_new.bss   = qry.bss;
      ent_new.rep   = qry.rep;
      stamp_new     = now;
    end else if ((qry.op == OP_SWEEP) && !flags.fresh) begin
      ent_new.valid = 1'b0;
    end
  end

endmodule

### rtl/aprt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aprt_checker
// Port-level checks of the aging pair report table.
// ----------------------------------------------------------------------------
module aprt_checker import aprt_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [119:0] out_tdata,
  input logic [3:0]   out_tuser,
  input logic         out_tlast
);

  // nothing pending right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result shown after reset");

  // a stalled result stays
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // single-result kinds always close their item
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] != KIND_DUMP) |-> out_tlast)
    else $error("single result without last");

  // a stalled result keeps its contents
  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

endmodule

bind aging_pair_report_table_core aprt_checker u_aprt_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata), .out_tuser(out_tuser),
  .out_tlast(out_tlast)
);

### sim/aging_pair_report_table_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_pair_report_table_core_tb
// Self-checking bench for the aging beacon report table.
// ----------------------------------------------------------------------------
// A clocked driver feeds items from a queue, and a clocked monitor compares
// each result with a software copy of the table. Both sides idle at random,
// the receiver holds off once for a long stretch, and the expiry is changed
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module aging_pair_report_table_core_tb;
  import aprt_pkg::*;

  localparam int NSLOT = 64;
  localparam int LIMIT = 3000000;

  typedef struct packed {
    logic [2:0]  op;
    logic [47:0] sta;
    logic [47:0] bss;
    logic [23:0] rep;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [47:0] sta;
    logic [47:0] bss;
    logic [23:0] rep;
    logic        last;
  } notice_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [119:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic in_fire = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [119:0] out_tdata;
  logic [3:0] out_tuser;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  // software copy of the table
  logic        tbl_valid [NSLOT];
  logic [47:0] tbl_sta [NSLOT];
  logic [47:0] tbl_bss [NSLOT];
  logic [23:0] tbl_rep [NSLOT];
  logic [31:0] tbl_stamp [NSLOT];
  logic [31:0] now_ticks;
  logic [15:0] expiry;

  item_t   pending_items[$];
  notice_t expected_notices[$];
  int      fail_count = 0;
  int      cycle_count = 0;
  int      hold_cycles = 0;
  bit      calm = 1'b0;

  always #5 clk = ~clk;

  aging_pair_report_table_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  function automatic bit slot_fresh(int i);
    logic [31:0] age;
    age = now_ticks - tbl_stamp[i];
    return tbl_valid[i] && (age < {16'd0, expiry});
  endfunction

  function automatic notice_t mk(logic [1:0] k, logic [1:0] s, logic [47:0] a,
                                 logic [47:0] b, logic [23:0] r, logic l);
    notice_t n;
    n.kind = k; n.status = s; n.sta = a; n.bss = b; n.rep = r; n.last = l;
    return n;
  endfunction

  // update the table copy and queue the expected results of one item
  task automatic predict_table(item_t it);
    int slot;
    int cnt;
    slot = -1;
    cnt = 0;
    case (it.op)
      OP_UPSERT: begin
        for (int i = 0; i < NSLOT; i++)
          if (slot < 0 && tbl_valid[i] && tbl_sta[i] == it.sta && tbl_bss[i] == it.bss)
            slot = i;
        for (int i = 0; i < NSLOT; i++)
          if (slot < 0 && !slot_fresh(i)) slot = i;
        if (slot < 0) begin
          expected_notices.push_back(mk(KIND_UPDATE, ST_FULL, it.sta, it.bss, '0, 1'b1));
        end else begin
          tbl_valid[slot] = 1'b1;
          tbl_sta[slot] = it.sta;
          tbl_bss[slot] = it.bss;
          tbl_rep[slot] = it.rep;
          tbl_stamp[slot] = now_ticks;
          expected_notices.push_back(mk(KIND_UPDATE, ST_OK, it.sta, it.bss, it.rep, 1'b1));
        end
      end
      OP_LOOKUP: begin
        for (int i = 0; i < NSLOT; i++)
          if (slot < 0 && slot_fresh(i) && tbl_sta[i] == it.sta && tbl_bss[i] == it.bss)
            slot = i;
        if (slot < 0)
          expected_notices.push_back(mk(KIND_LOOKUP, ST_MISS, it.sta, it.bss, '0, 1'b1));
        else
          expected_notices.push_back(mk(KIND_LOOKUP, ST_OK, it.sta, it.bss,
                                        tbl_rep[slot], 1'b1));
      end
      OP_DUMP: begin
        for (int i = 0; i < NSLOT; i++)
          if (slot_fresh(i)) begin
            expected_notices.push_back(mk(KIND_DUMP, ST_OK, tbl_sta[i], tbl_bss[i],
                                          tbl_rep[i], 1'b0));
            cnt++;
          end
        if (cnt == 0)
          expected_notices.push_back(mk(KIND_DUMP, ST_EMPTY, '0, '0, '0, 1'b1));
        else
          expected_notices[$].last = 1'b1;
      end
      OP_TICK: begin
        now_ticks = now_ticks + 32'd1;
        expected_notices.push_back(mk(KIND_ACK, ST_OK, '0, '0, '0, 1'b1));
      end
      OP_SWEEP: begin
        for (int i = 0; i < NSLOT; i++)
          if (!slot_fresh(i)) tbl_valid[i] = 1'b0;
        expected_notices.push_back(mk(KIND_ACK, ST_OK, '0, '0, '0, 1'b1));
      end
      default: ;
    endcase
  endtask

  // remember whether the offered item was taken at the last rising edge
  always @(posedge clk) begin
    in_fire <= in_tvalid && in_tready;
  end

  // driver: next item presented after the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && !in_fire) begin
        // hold the offered item
      end else if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 14)) begin
        in_tvalid <= 1'b1;
        in_tdata <= {pending_items[0].rep[23:16], pending_items[0].rep[15:8],
                     pending_items[0].rep[7:0], pending_items[0].bss, pending_items[0].sta};
        in_tuser <= pending_items[0].op;
        void'(pending_items.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver ready, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 14);
    end
  end

  // monitor: predict on input accept, check on output accept
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && in_tvalid && in_tready)
      predict_table(item_t'({in_tuser, in_tdata[47:0], in_tdata[95:48],
                             in_tdata[119:96]}));
    if (rst_n && out_tvalid && out_tready) begin
      notice_t got;
      got = mk(out_tuser[1:0], out_tuser[3:2], out_tdata[47:0], out_tdata[95:48],
               out_tdata[119:96], out_tlast);
      if (expected_notices.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
        fail_count++;
      end else begin
        if (got !== expected_notices[0]) begin
          $display("%0t: mismatch, expected %h, actual %h (kind status sta bss rep last)",
                   $realtime, expected_notices[0], got);
          fail_count++;
        end
        void'(expected_notices.pop_front());
      end
    end
    if (cycle_count > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [47:0] rnd48();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic item_t rnd_item();
    item_t it;
    int sel;
    sel = $urandom_range(99);
    it.sta = {40'h02_0000_0000, 8'($urandom_range(11))};
    it.bss = {40'h0A_0000_0000, 8'($urandom_range(3))};
    it.rep = 24'($urandom());
    if (sel < 5) begin
      it.sta = rnd48();
      it.bss = rnd48();
    end
    if (sel < 38) it.op = OP_UPSERT;
    else if (sel < 62) it.op = OP_LOOKUP;
    else if (sel < 70) it.op = OP_DUMP;
    else if (sel < 90) it.op = OP_TICK;
    else if (sel < 97) it.op = OP_SWEEP;
    else it.op = 3'($urandom_range(7, 5));
    return it;
  endfunction

  function automatic item_t one(logic [2:0] op, logic [47:0] a, logic [47:0] b,
                                logic [23:0] r);
    item_t it;
    it.op = op; it.sta = a; it.bss = b; it.rep = r;
    return it;
  endfunction

  task automatic drain();
    while (pending_items.size() > 0 || expected_notices.size() > 0 || in_tvalid)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_expiry(logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    expiry = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      tbl_valid[i] = 1'b0; tbl_sta[i] = '0; tbl_bss[i] = '0;
      tbl_rep[i] = '0; tbl_stamp[i] = '0;
    end
    now_ticks = '0;
    expiry = 16'd10;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every opcode, misses, stale, empty dump, bad opcodes
    pending_items.push_back(one(OP_DUMP, '0, '0, '0));
    pending_items.push_back(one(OP_LOOKUP, '1, '1, '0));
    pending_items.push_back(one(OP_UPSERT, '0, '0, 24'h000000));
    pending_items.push_back(one(OP_UPSERT, '1, '1, 24'hFFFFFF));
    pending_items.push_back(one(OP_UPSERT, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 24'h5A5A5A));
    pending_items.push_back(one(OP_UPSERT, '1, '1, 24'h123456));
    pending_items.push_back(one(OP_LOOKUP, '1, '1, '0));
    pending_items.push_back(one(OP_LOOKUP, '1, '0, '0));
    pending_items.push_back(one(3'd5, '1, '1, '1));
    pending_items.push_back(one(3'd6, '0, '0, '0));
    pending_items.push_back(one(3'd7, '1, '0, '1));
    pending_items.push_back(one(OP_DUMP, '0, '0, '0));
    for (int i = 0; i < 10; i++) pending_items.push_back(one(OP_TICK, '0, '0, '0));
    pending_items.push_back(one(OP_LOOKUP, '0, '0, '0));
    pending_items.push_back(one(OP_SWEEP, '0, '0, '0));
    pending_items.push_back(one(OP_DUMP, '0, '0, '0));
    drain();

    // fill the table to force the full status, with a long receiver stall
    write_expiry(16'hFFFF);
    for (int i = 0; i < NSLOT + 3; i++)
      pending_items.push_back(one(OP_UPSERT, 48'(i), 48'hB55_0000 + 48'(i),
                                  24'($urandom())));
    pending_items.push_back(one(OP_DUMP, '0, '0, '0));
    pending_items.push_back(one(OP_LOOKUP, 48'd5, 48'hB55_0005, '0));
    repeat (3) @(posedge clk);
    @(negedge clk);
    hold_cycles <= 400;
    drain();

    // expiry zero: everything stale
    write_expiry(16'd0);
    pending_items.push_back(one(OP_LOOKUP, 48'd1, 48'hB55_0001, '0));
    pending_items.push_back(one(OP_DUMP, '0, '0, '0));
    pending_items.push_back(one(OP_UPSERT, 48'd999, 48'd999, 24'hABCDEF));
    pending_items.push_back(one(OP_SWEEP, '0, '0, '0));
    drain();

    // random phases at several expiry settings, one without idling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_expiry(16'd1);
        1: write_expiry(16'd6);
        2: write_expiry(16'd10);
        default: write_expiry(16'd30);
      endcase
      calm = (ph == 2);
      for (int n = 0; n < 56; n++) pending_items.push_back(rnd_item());
      drain();
    end
    calm = 1'b0;

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
